[hw/rtl/tsfc_pkg.sv]
package tsfc_pkg;

  typedef enum logic [1:0] {
    FMT_TIMESPEC = 2'd0,
    FMT_TOD      = 2'd1,
    FMT_NTP      = 2'd2,
    FMT_NTP_ZERO = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [63:0] raw_bytes;
    fmt_t        format_code;
    logic        little_endian;
    logic        is_eight_bytes;
    logic        relative_stamp;
  } in_item_t;

  typedef struct packed {
    logic signed [32:0] seconds;
    logic [31:0]        nanoseconds;
    logic               converted;
  } out_item_t;

  // Per-item sideband carried alongside the divider
  typedef struct packed {
    logic        is_tod;
    logic        rejected;
    logic        use_us;
    logic [32:0] sec;
    logic [31:0] ns_word;
  } side_t;

  localparam logic [33:0] EPOCH_1900     = 34'd2208988800;
  localparam logic [19:0] MICRO_PER_SEC  = 20'd1000000;
  localparam logic [9:0]  NANO_PER_MICRO = 10'd1000;
  localparam int          TOD_SHIFT      = 12;

endpackage

[hw/rtl/timestamp_format_converter_core.sv]
// Timestamp format converter.
//
// Input channel: in_data carries one raw wire stamp with its format, byte
// order, length and relative flag. A stamp transfers on a rising edge with
// start high and busy low. busy is held low: a new stamp may be offered
// in every cycle.
// Result channel: out_data is valid for exactly one cycle while out_valid
// is high. The receiver cannot stall, so nothing holds results back.
//
// Throughput is one stamp per cycle. The pipeline depth is set by the TOD
// path: the stamp passes the input stage, the divider and the output stage;
// the 52-bit clock value is divided by one million in a pipelined
// radix-4 divider of 17 stages, two quotient bits per stage, between an
// input stage (byte order, NTP fraction multiply) and an output stage
// (epoch subtract, scale by 1000).
//
// Reset clears all stage valid bits; stamps in flight are dropped and no
// result is strobed until new stamps arrive.
module timestamp_format_converter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tsfc_pkg::in_item_t in_data,
  output logic               out_valid,
  output tsfc_pkg::out_item_t out_data
);

  localparam int DIV_STEPS = 17;
  localparam logic [21:0] DIV1 = 22'd1000000;
  localparam logic [21:0] DIV2 = 22'd2000000;
  localparam logic [21:0] DIV3 = 22'd3000000;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    swap64 = {swap32(v[31:0]), swap32(v[63:32])};
  endfunction

  // Stage arrays: index 0 is the input stage, 1..DIV_STEPS the divider
  logic                  vld_r   [0:DIV_STEPS];
  logic                  vld_nxt [0:DIV_STEPS];
  tsfc_pkg::side_t       side_r  [0:DIV_STEPS];
  tsfc_pkg::side_t       side_nxt[0:DIV_STEPS];
  logic [19:0]           rem_r   [0:DIV_STEPS];
  logic [19:0]           rem_nxt [0:DIV_STEPS];
  logic [33:0]           quo_r   [0:DIV_STEPS];
  logic [33:0]           quo_nxt [0:DIV_STEPS];
  logic [33:0]           low_r   [0:DIV_STEPS];
  logic [33:0]           low_nxt [0:DIV_STEPS];

  logic                  out_valid_r, out_valid_nxt;
  tsfc_pkg::out_item_t   out_data_r, out_data_nxt;

  assign busy = 1'b0;

  // Input stage
  logic [31:0] w0, w1, ntp_sec;
  logic [63:0] tod_word;
  logic [51:0] tod_t;
  logic [51:0] frac_prod;
  logic [19:0] frac_us;

  always_comb begin
    w0       = in_data.little_endian ? swap32(in_data.raw_bytes[63:32])
                                     : in_data.raw_bytes[63:32];
    w1       = in_data.little_endian ? swap32(in_data.raw_bytes[31:0])
                                     : in_data.raw_bytes[31:0];
    tod_word = in_data.little_endian ? swap64(in_data.raw_bytes) : in_data.raw_bytes;
    tod_t    = tod_word[63:tsfc_pkg::TOD_SHIFT];
    frac_prod = 52'(w1) * 52'(tsfc_pkg::MICRO_PER_SEC);
    frac_us  = frac_prod[51:32];
    ntp_sec  = (w0 != 32'd0) ? (w0 - tsfc_pkg::EPOCH_1900[31:0]) : 32'd0;

    side_nxt[0].is_tod   = 1'b0;
    side_nxt[0].rejected = in_data.relative_stamp &&
                           (in_data.format_code != tsfc_pkg::FMT_TIMESPEC);
    side_nxt[0].use_us   = 1'b0;
    side_nxt[0].sec      = {1'b0, w0};
    side_nxt[0].ns_word  = 32'd0;
    case (in_data.format_code)
      tsfc_pkg::FMT_TIMESPEC: begin
        side_nxt[0].ns_word = in_data.is_eight_bytes ? w1 : 32'd0;
      end
      tsfc_pkg::FMT_TOD: begin
        side_nxt[0].is_tod = 1'b1;
      end
      tsfc_pkg::FMT_NTP: begin
        side_nxt[0].sec     = {1'b0, ntp_sec};
        side_nxt[0].use_us  = 1'b1;
        side_nxt[0].ns_word = in_data.is_eight_bytes ? {12'd0, frac_us} : 32'd0;
      end
      default: begin
        side_nxt[0].use_us  = 1'b1;
        side_nxt[0].ns_word = in_data.is_eight_bytes ? {12'd0, frac_us} : 32'd0;
      end
    endcase

    vld_nxt[0] = start && !busy;
    // Top 18 bits are always below one million: seed the remainder with them
    rem_nxt[0] = {2'd0, tod_t[51:34]};
    quo_nxt[0] = 34'd0;
    low_nxt[0] = tod_t[33:0];
  end

  // Divider stages: shift in two dividend bits, retire two quotient bits
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [21:0] x;
    always_comb begin
      x = {rem_r[k-1], low_r[k-1][33:32]};
      if (x >= DIV3) begin
        rem_nxt[k] = 20'(x - DIV3);
        quo_nxt[k] = {quo_r[k-1][31:0], 2'd3};
      end else if (x >= DIV2) begin
        rem_nxt[k] = 20'(x - DIV2);
        quo_nxt[k] = {quo_r[k-1][31:0], 2'd2};
      end else if (x >= DIV1) begin
        rem_nxt[k] = 20'(x - DIV1);
        quo_nxt[k] = {quo_r[k-1][31:0], 2'd1};
      end else begin
        rem_nxt[k] = x[19:0];
        quo_nxt[k] = {quo_r[k-1][31:0], 2'd0};
      end
      low_nxt[k]  = {low_r[k-1][31:0], 2'd0};
      side_nxt[k] = side_r[k-1];
      vld_nxt[k]  = vld_r[k-1];
    end
  end

  for (genvar s = 0; s <= DIV_STEPS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      side_r[s] <= side_nxt[s];
      rem_r[s]  <= rem_nxt[s];
      quo_r[s]  <= quo_nxt[s];
      low_r[s]  <= low_nxt[s];
    end
  end

  // Output stage
  tsfc_pkg::side_t fin_side;
  logic [19:0]     micro;
  logic [29:0]     ns_scaled;
  logic [33:0]     tod_sec;

  always_comb begin
    fin_side  = side_r[DIV_STEPS];
    micro     = fin_side.is_tod ? rem_r[DIV_STEPS] : fin_side.ns_word[19:0];
    ns_scaled = 30'(micro) * 30'(tsfc_pkg::NANO_PER_MICRO);
    tod_sec   = quo_r[DIV_STEPS] - tsfc_pkg::EPOCH_1900;

    out_valid_nxt = vld_r[DIV_STEPS];
    if (fin_side.rejected) begin
      out_data_nxt.seconds     = 33'sd0;
      out_data_nxt.nanoseconds = 32'd0;
      out_data_nxt.converted   = 1'b0;
    end else if (fin_side.is_tod) begin
      out_data_nxt.seconds     = tod_sec[32:0];
      out_data_nxt.nanoseconds = {2'd0, ns_scaled};
      out_data_nxt.converted   = 1'b1;
    end else begin
      out_data_nxt.seconds     = fin_side.sec;
      out_data_nxt.nanoseconds = fin_side.use_us ? {2'd0, ns_scaled} : fin_side.ns_word;
      out_data_nxt.converted   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
